// ----- rtl/core/pmld_pkg.sv -----
// Shared constants, marker table and result type for the marker line detector.
package pmld_pkg;

    localparam int OFFSET_BITS_DEFAULT = 32;
    localparam int MARKER_LEN          = 18;
    localparam int MATCH_BITS          = 5;
    localparam int RESULT_BITS         = 32;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // One finished result, already cut to the output width.
    typedef struct packed {
        logic                   found;
        logic [RESULT_BITS-1:0] marker_end;
        logic [RESULT_BITS-1:0] rev_start;
        logic [RESULT_BITS-1:0] rev_stop;
    } result_t;

    // Marker text "#pragma " followed by the ten-letter tool word.
    function automatic logic [7:0] marker_byte(input logic [MATCH_BITS-1:0] idx);
        logic [7:0] b;
        unique case (idx)
            5'd0:    b = 8'h23;
            5'd1:    b = 8'h70;
            5'd2:    b = 8'h72;
            5'd3:    b = 8'h61;
            5'd4:    b = 8'h67;
            5'd5:    b = 8'h6D;
            5'd6:    b = 8'h61;
            5'd7:    b = 8'h20;
            5'd8:    b = 8'h63;
            5'd9:    b = 8'h65;
            5'd10:   b = 8'h6C;
            5'd11:   b = 8'h6C;
            5'd12:   b = 8'h65;
            5'd13:   b = 8'h72;
            5'd14:   b = 8'h61;
            5'd15:   b = 8'h74;
            5'd16:   b = 8'h6F;
            5'd17:   b = 8'h72;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR);
    endfunction

endpackage

// ----- rtl/core/pmld_scan.sv -----
// Per-byte scan state machine: marker match, revision span tracking, result.
module pmld_scan #(
    parameter int OFFSET_BITS = pmld_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output logic              hit,
    output pmld_pkg::result_t res
);

    typedef enum logic [2:0] {
        PH_LINE_BLANK  = 3'd0,
        PH_MATCH       = 3'd1,
        PH_CHECK_AFTER = 3'd2,
        PH_REV_BLANK   = 3'd3,
        PH_REV_BODY    = 3'd4,
        PH_SKIP_LINE   = 3'd5,
        PH_DONE        = 3'd6
    } phase_t;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    phase_t                              phase_reg, phase_next;
    logic [pmld_pkg::MATCH_BITS-1:0]     match_reg, match_next;
    logic [OFFSET_BITS-1:0]              pos_reg, pos_next;
    logic [OFFSET_BITS-1:0]              me_reg, me_next;
    logic [OFFSET_BITS-1:0]              rb_reg, rb_next;
    logic [OFFSET_BITS-1:0]              te_reg, te_next;

    logic [OFFSET_BITS-1:0] nxt;
    logic [OFFSET_BITS-1:0] r_me, r_rb, r_re;
    logic                   blank, nl, r_found;

    assign nxt   = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
    assign blank = pmld_pkg::is_blank(data_byte);
    assign nl    = (data_byte == pmld_pkg::CH_LF);

    always_comb
    begin
        phase_next = phase_reg;
        match_next = match_reg;
        pos_next   = pos_reg;
        me_next    = me_reg;
        rb_next    = rb_reg;
        te_next    = te_reg;
        hit        = 1'b0;
        r_found    = 1'b0;
        r_me       = '0;
        r_rb       = '0;
        r_re       = '0;

        unique case (phase_reg)
            PH_MATCH:
            begin
                if ((match_reg < pmld_pkg::MATCH_BITS'(pmld_pkg::MARKER_LEN)) &&
                    (data_byte == pmld_pkg::marker_byte(match_reg)))
                begin
                    match_next = match_reg + 1'b1;
                    if (match_next >= pmld_pkg::MATCH_BITS'(pmld_pkg::MARKER_LEN))
                    begin
                        me_next    = nxt;
                        phase_next = PH_CHECK_AFTER;
                    end
                end
                else
                begin
                    phase_next = nl ? PH_LINE_BLANK : PH_SKIP_LINE;
                end
            end
            PH_CHECK_AFTER:
            begin
                if (blank)
                    phase_next = PH_REV_BLANK;
                else if (nl)
                begin
                    hit        = 1'b1;
                    r_found    = 1'b1;
                    r_me       = me_reg;
                    r_rb       = pos_reg;
                    r_re       = pos_reg;
                    phase_next = PH_DONE;
                end
                else
                    phase_next = PH_SKIP_LINE;
            end
            PH_REV_BLANK:
            begin
                if (nl)
                begin
                    hit        = 1'b1;
                    r_found    = 1'b1;
                    r_me       = me_reg;
                    r_rb       = pos_reg;
                    r_re       = pos_reg;
                    phase_next = PH_DONE;
                end
                else if (!blank)
                begin
                    rb_next    = pos_reg;
                    te_next    = nxt;
                    phase_next = PH_REV_BODY;
                end
            end
            PH_REV_BODY:
            begin
                if (nl)
                begin
                    hit        = 1'b1;
                    r_found    = 1'b1;
                    r_me       = me_reg;
                    r_rb       = rb_reg;
                    r_re       = te_reg;
                    phase_next = PH_DONE;
                end
                else if (!blank)
                    te_next = nxt;
            end
            PH_SKIP_LINE:
            begin
                if (nl)
                    phase_next = PH_LINE_BLANK;
            end
            PH_DONE:
            begin
            end
            default:
            begin
                // line start, and unused codes
                if (blank || nl)
                    phase_next = PH_LINE_BLANK;
                else if (data_byte == pmld_pkg::marker_byte('0))
                begin
                    match_next = pmld_pkg::MATCH_BITS'(1);
                    phase_next = PH_MATCH;
                end
                else
                    phase_next = PH_SKIP_LINE;
            end
        endcase

        if (last_byte)
        begin
            // end of file: flush a pending line or report not found, then re-arm
            if (!hit && (phase_next != PH_DONE))
            begin
                hit = 1'b1;
                unique case (phase_next)
                    PH_CHECK_AFTER:
                    begin
                        r_found = 1'b1;
                        r_me    = me_next;
                        r_rb    = me_next;
                        r_re    = me_next;
                    end
                    PH_REV_BLANK:
                    begin
                        r_found = 1'b1;
                        r_me    = me_next;
                        r_rb    = nxt;
                        r_re    = nxt;
                    end
                    PH_REV_BODY:
                    begin
                        r_found = 1'b1;
                        r_me    = me_next;
                        r_rb    = rb_next;
                        r_re    = te_next;
                    end
                    default:
                    begin
                        r_found = 1'b0;
                    end
                endcase
            end
            phase_next = PH_LINE_BLANK;
            match_next = '0;
            pos_next   = '0;
        end
        else
        begin
            pos_next = nxt;
        end
    end

    assign res.found      = r_found;
    assign res.marker_end = pmld_pkg::RESULT_BITS'(r_me);
    assign res.rev_start  = pmld_pkg::RESULT_BITS'(r_rb);
    assign res.rev_stop   = pmld_pkg::RESULT_BITS'(r_re);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LINE_BLANK;
            match_reg <= '0;
            pos_reg   <= '0;
            me_reg    <= '0;
            rb_reg    <= '0;
            te_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            match_reg <= match_next;
            pos_reg   <= pos_next;
            me_reg    <= me_next;
            rb_reg    <= rb_next;
            te_reg    <= te_next;
        end
    end

endmodule

// ----- rtl/core/pragma_marker_line_detector_top.sv -----
// Top level of the marker line detector: input register, scanner, result register.
//
// Usage: a file is streamed in as items of one byte (data_byte) with last_byte
// set on its final byte, over a valid/ready channel (in_valid, in_ready).
// For each file exactly one result item leaves on the out_valid/out_ready
// channel: found, marker_end, rev_start, rev_stop. It appears after
// the newline that closes the first marker line, or after the final byte when
// the file ends inside that line or holds no marker line. Bytes that follow a
// delivered result are consumed without effect until the final byte, which
// re-arms the scanner for the next file.
// An accepted byte lands in the input register and is scanned from there once
// the result register can take its outcome; a result it completes is loaded
// into the result register, which drives out_valid.
// Throughput is one byte per cycle as long as no result waits or the receiver
// takes the waiting one.
// Stall: while a result waits with out_ready low the scanner stops, the next
// byte stays in the input register and in_ready is low once that register is
// full. Reset (rst_n low) empties both registers and returns the scanner
// to the start of a line at offset zero.
module pragma_marker_line_detector_top #(
    parameter int OFFSET_BITS = pmld_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [31:0] marker_end,
    output logic [31:0] rev_start,
    output logic [31:0] rev_stop
);

    // input register
    logic              in_valid_reg;
    logic [7:0]        byte_reg;
    logic              last_reg;

    // result register
    logic              out_valid_reg;
    pmld_pkg::result_t res_reg;

    logic              step;
    logic              hit;
    pmld_pkg::result_t res;

    // Scan the held byte when the result register can take whatever it yields.
    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    pmld_scan #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (byte_reg),
        .last_byte (last_reg),
        .hit       (hit),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (step && hit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
        if (step && hit)
            res_reg <= res;
    end

    assign out_valid  = out_valid_reg;
    assign found      = res_reg.found;
    assign marker_end = res_reg.marker_end;
    assign rev_start  = res_reg.rev_start;
    assign rev_stop   = res_reg.rev_stop;

endmodule
